// File: hdl/mau_pkg.sv
// ----------------------------------------------------------------------------
// mau_pkg
// Shared widths, operation codes and controller states of the modular
// arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

    localparam int RES_W = 31;
    localparam int EXP_W = 63;
    localparam int RAW_W = 64;
    localparam int OP_W  = 3;
    localparam int CNT_W = 7;

    localparam logic [RES_W-1:0] MODULUS_RESET = 31'd1000000007;

    typedef enum logic [OP_W-1:0] {
        OP_REDUCE = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_NEG    = 3'd5,
        OP_POW    = 3'd6,
        OP_EQUAL  = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_RED_RAW,
        S_DISPATCH,
        S_EUC,
        S_EUC_FIX,
        S_MUL,
        S_POW,
        S_POW_ACC,
        S_POW_SQ,
        S_OUT
    } state_t;

endpackage

// File: hdl/mau_req_if.sv
// ----------------------------------------------------------------------------
// mau_req_if
// Request channel: one operation and its operands per beat.
// ----------------------------------------------------------------------------
interface mau_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [mau_pkg::OP_W-1:0]              op;
    logic [mau_pkg::RES_W-1:0]             operand_a;
    logic [mau_pkg::RES_W-1:0]             operand_b;
    logic [mau_pkg::EXP_W-1:0]             exponent;
    logic signed [mau_pkg::RAW_W-1:0]      raw_value;

    modport source (output valid, op, operand_a, operand_b, exponent, raw_value,
                    input ready);
    modport sink   (input valid, op, operand_a, operand_b, exponent, raw_value,
                    output ready);
endinterface

// File: hdl/mau_rsp_if.sv
// ----------------------------------------------------------------------------
// mau_rsp_if
// Response channel: one residue and one equality flag per beat.
// ----------------------------------------------------------------------------
interface mau_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [mau_pkg::RES_W-1:0] result;
    logic                      is_equal;

    modport source (output valid, result, is_equal, input ready);
    modport sink   (input valid, result, is_equal, output ready);
endinterface

// File: hdl/mau_mulmod.sv
// ----------------------------------------------------------------------------
// mau_mulmod
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first,
// with a doubling and an add each reduced by one compare and subtract.
// ----------------------------------------------------------------------------
module mau_mulmod
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [mau_pkg::RES_W-1:0] x,
    input  logic [mau_pkg::RES_W-1:0] y,
    input  logic [mau_pkg::RES_W-1:0] modulus,
    output logic                      done,
    output logic [mau_pkg::RES_W-1:0] prod
);

    localparam int CW = $clog2(mau_pkg::RES_W);

    logic                      busy_reg;
    logic                      done_reg;
    logic [CW-1:0]             cnt_reg;
    logic [mau_pkg::RES_W-1:0] acc_reg;
    logic [mau_pkg::RES_W-1:0] x_reg;
    logic [mau_pkg::RES_W-1:0] y_reg;

    logic [mau_pkg::RES_W:0]   dbl;
    logic [mau_pkg::RES_W:0]   dbl_red;
    logic [mau_pkg::RES_W:0]   add;
    logic [mau_pkg::RES_W:0]   acc_next;
    logic [mau_pkg::RES_W:0]   m_ext;

    always_comb
    begin
        m_ext    = {1'b0, modulus};
        dbl      = {acc_reg, 1'b0};
        dbl_red  = (dbl >= m_ext) ? dbl - m_ext : dbl;
        add      = dbl_red + (y_reg[mau_pkg::RES_W-1] ? {1'b0, x_reg} : '0);
        acc_next = (add >= m_ext) ? add - m_ext : add;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            x_reg   <= x;
            y_reg   <= y;
            cnt_reg <= CW'(mau_pkg::RES_W - 1);
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next[mau_pkg::RES_W-1:0];
            y_reg   <= {y_reg[mau_pkg::RES_W-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: hdl/modular_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_core
// Modular arithmetic unit over a programmable modulus, built around a
// bit-serial reducer, a bit-serial Euclid divider and a serial multiplier.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload                                      Handshake
//  req      in         op, operand_a, operand_b, exponent, raw_value valid/ready
//  rsp      out        result, is_equal                             valid/ready
//  cfg      in         cfg_wr_data (modulus)                        cfg_wr_en
//
// One request is worked on at a time; a modulus below 2 sends it straight to
// the output. Reducing a raw value shifts its 64-bit magnitude in one bit at a
// time. Other operations first reduce both operands the same way, then add,
// subtract, negate and equal finish in the dispatch state, multiply runs one
// serial multiply, divide runs the Euclid loop at one quotient bit per cycle
// within a step (about 45 steps at most) followed by one multiply, and power
// spends one squaring per exponent bit up to the highest set bit, plus one
// more multiply for each set bit. All multiplies share the serial multiplier.
// Reset is asynchronous and loads the modulus with 1000000007. The finished
// result moves into an output register, so a stalled response does not hold
// up the next request except when a second result is ready before the first
// one is taken.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [mau_pkg::RES_W-1:0] cfg_wr_data,
    mau_req_if.sink                   req,
    mau_rsp_if.source                 rsp
);

    localparam int W = mau_pkg::RES_W;

    mau_pkg::state_t state_reg;
    mau_pkg::state_t state_next;

    logic [W-1:0]                  modulus_reg;

    // Request and working registers.
    mau_pkg::op_t                  op_reg;
    logic [W-1:0]                  a_reg;
    logic [W-1:0]                  b_reg;
    logic [mau_pkg::EXP_W-1:0]     exp_reg;
    logic [mau_pkg::RAW_W-1:0]     sh_reg;
    logic [W-1:0]                  rem_reg;
    logic [mau_pkg::CNT_W-1:0]     cnt_reg;
    logic                          neg_reg;

    // Extended Euclid state: remainders, shifted divisor, coefficients.
    logic [W-1:0]                  ea_reg;
    logic [W-1:0]                  eb_reg;
    logic [2*W-2:0]                bs_reg;
    logic signed [W+2:0]           tv_reg;
    logic signed [W+2:0]           u_reg;
    logic signed [W+2:0]           v_reg;

    // Square-and-multiply state.
    logic [W-1:0]                  acc_reg;
    logic [W-1:0]                  base_reg;

    logic [W-1:0]                  res_reg;
    logic                          eq_reg;

    logic                          out_valid_reg;
    logic [W-1:0]                  out_res_reg;
    logic                          out_eq_reg;

    // Combinational values.
    logic                          accept;
    logic                          m_small;
    logic                          cnt_last;
    logic                          out_load;
    logic [W:0]                    m_ext;
    logic [W:0]                    red_t;
    logic [W-1:0]                  red_rem;
    logic [W-1:0]                  raw_res;
    logic [mau_pkg::RAW_W-1:0]     raw_mag;
    logic                          div_ge;
    logic [W-1:0]                  div_rem;
    logic signed [W+2:0]           div_tv;
    logic signed [W+2:0]           m_sgn;
    logic signed [W+2:0]           coef_full;
    logic [W-1:0]                  coef;
    logic [W:0]                    sum;
    logic [W-1:0]                  add_res;
    logic [W:0]                    diff;
    logic [W-1:0]                  sub_res;
    logic [W-1:0]                  neg_res;

    logic                          mul_start;
    logic [W-1:0]                  mul_x;
    logic [W-1:0]                  mul_y;
    logic                          mul_done;
    logic [W-1:0]                  mul_prod;

    mau_mulmod u_mulmod
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .x       (mul_x),
        .y       (mul_y),
        .modulus (modulus_reg),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    // Datapath arithmetic.
    always_comb
    begin
        accept   = req.valid && req.ready;
        m_small  = modulus_reg < W'(2);
        cnt_last = cnt_reg == mau_pkg::CNT_W'(1);
        m_ext    = {1'b0, modulus_reg};

        // One step of restoring reduction: shift in the next bit, subtract once.
        red_t    = {rem_reg, sh_reg[mau_pkg::RAW_W-1]};
        red_rem  = (red_t >= m_ext) ? W'(red_t - m_ext) : red_t[W-1:0];
        raw_res  = !neg_reg ? red_rem
                 : (red_rem != '0) ? W'(m_ext - {1'b0, red_rem}) : '0;
        raw_mag  = req.raw_value[mau_pkg::RAW_W-1] ? (~req.raw_value + 1'b1)
                                                   : req.raw_value;

        // One quotient bit of the Euclid step, with t*v built MSB first.
        div_ge   = bs_reg <= {{(W-1){1'b0}}, ea_reg};
        div_rem  = div_ge ? W'(ea_reg - bs_reg[W-1:0]) : ea_reg;
        div_tv   = {tv_reg[W+1:0], 1'b0} + (div_ge ? v_reg : '0);

        // Coefficient folded into 0..m-1 the way a truncating remainder does.
        m_sgn     = {3'b000, modulus_reg};
        coef_full = (u_reg == m_sgn || u_reg == -m_sgn) ? '0
                  : (u_reg < 0) ? u_reg + m_sgn : u_reg;
        coef      = coef_full[W-1:0];

        sum      = {1'b0, a_reg} + {1'b0, b_reg};
        add_res  = (sum >= m_ext) ? W'(sum - m_ext) : sum[W-1:0];
        diff     = (a_reg >= b_reg) ? {1'b0, a_reg} - {1'b0, b_reg}
                                    : {1'b0, a_reg} + m_ext - {1'b0, b_reg};
        sub_res  = diff[W-1:0];
        neg_res  = (a_reg != '0) ? W'(m_ext - {1'b0, a_reg}) : '0;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mau_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (m_small)
                        state_next = mau_pkg::S_OUT;
                    else if (req.op == mau_pkg::OP_REDUCE)
                        state_next = mau_pkg::S_RED_RAW;
                    else
                        state_next = mau_pkg::S_RED_A;
                end
            end
            mau_pkg::S_RED_A:
            begin
                if (cnt_last)
                    state_next = mau_pkg::S_RED_B;
            end
            mau_pkg::S_RED_B:
            begin
                if (cnt_last)
                    state_next = mau_pkg::S_DISPATCH;
            end
            mau_pkg::S_RED_RAW:
            begin
                if (cnt_last)
                    state_next = mau_pkg::S_OUT;
            end
            mau_pkg::S_DISPATCH:
            begin
                case (op_reg)
                    mau_pkg::OP_MUL: state_next = mau_pkg::S_MUL;
                    mau_pkg::OP_DIV: state_next = mau_pkg::S_EUC;
                    mau_pkg::OP_POW: state_next = mau_pkg::S_POW;
                    default:         state_next = mau_pkg::S_OUT;
                endcase
            end
            mau_pkg::S_EUC:
            begin
                if (cnt_reg == '0 && eb_reg == '0)
                    state_next = mau_pkg::S_EUC_FIX;
            end
            mau_pkg::S_EUC_FIX:
            begin
                state_next = mau_pkg::S_MUL;
            end
            mau_pkg::S_MUL:
            begin
                if (mul_done)
                    state_next = mau_pkg::S_OUT;
            end
            mau_pkg::S_POW:
            begin
                if (exp_reg == '0)
                    state_next = mau_pkg::S_OUT;
                else if (exp_reg[0])
                    state_next = mau_pkg::S_POW_ACC;
                else
                    state_next = mau_pkg::S_POW_SQ;
            end
            mau_pkg::S_POW_ACC:
            begin
                if (mul_done)
                    state_next = mau_pkg::S_POW_SQ;
            end
            mau_pkg::S_POW_SQ:
            begin
                if (mul_done)
                    state_next = mau_pkg::S_POW;
            end
            mau_pkg::S_OUT:
            begin
                if (out_load)
                    state_next = mau_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mau_pkg::S_IDLE;
            end
        endcase
    end

    // Controller outputs: handshake and multiplier launches.
    always_comb
    begin
        req.ready = state_reg == mau_pkg::S_IDLE;
        out_load  = (state_reg == mau_pkg::S_OUT) && (!out_valid_reg || rsp.ready);
        mul_start = 1'b0;
        mul_x     = a_reg;
        mul_y     = b_reg;
        case (state_reg)
            mau_pkg::S_DISPATCH:
            begin
                mul_start = op_reg == mau_pkg::OP_MUL;
            end
            mau_pkg::S_EUC_FIX:
            begin
                mul_start = 1'b1;
                mul_y     = coef;
            end
            mau_pkg::S_POW:
            begin
                mul_start = exp_reg != '0;
                mul_x     = exp_reg[0] ? acc_reg : base_reg;
                mul_y     = base_reg;
            end
            mau_pkg::S_POW_ACC:
            begin
                mul_start = mul_done;
                mul_x     = base_reg;
                mul_y     = base_reg;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mau_pkg::S_IDLE;
            modulus_reg   <= mau_pkg::MODULUS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                modulus_reg <= cfg_wr_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_res_reg <= res_reg;
            out_eq_reg  <= eq_reg;
        end
        case (state_reg)
            mau_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_reg  <= mau_pkg::op_t'(req.op);
                    a_reg   <= req.operand_a;
                    b_reg   <= req.operand_b;
                    exp_reg <= req.exponent;
                    res_reg <= '0;
                    eq_reg  <= m_small && (req.op == mau_pkg::OP_EQUAL)
                               && (req.operand_a == req.operand_b);
                    rem_reg <= '0;
                    neg_reg <= req.raw_value[mau_pkg::RAW_W-1];
                    if (req.op == mau_pkg::OP_REDUCE)
                    begin
                        sh_reg  <= raw_mag;
                        cnt_reg <= mau_pkg::CNT_W'(mau_pkg::RAW_W);
                    end
                    else
                    begin
                        sh_reg  <= {req.operand_a, {(mau_pkg::RAW_W-W){1'b0}}};
                        cnt_reg <= mau_pkg::CNT_W'(W);
                    end
                end
            end
            mau_pkg::S_RED_A, mau_pkg::S_RED_B, mau_pkg::S_RED_RAW:
            begin
                if (cnt_last && state_reg == mau_pkg::S_RED_A)
                begin
                    // Operand a is done; load operand b for the next pass.
                    a_reg   <= red_rem;
                    sh_reg  <= {b_reg, {(mau_pkg::RAW_W-W){1'b0}}};
                    rem_reg <= '0;
                    cnt_reg <= mau_pkg::CNT_W'(W);
                end
                else
                begin
                    rem_reg <= red_rem;
                    sh_reg  <= {sh_reg[mau_pkg::RAW_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_last)
                    begin
                        if (state_reg == mau_pkg::S_RED_B)
                            b_reg <= red_rem;
                        else
                            res_reg <= raw_res;
                    end
                end
            end
            mau_pkg::S_DISPATCH:
            begin
                case (op_reg)
                    mau_pkg::OP_ADD:   res_reg <= add_res;
                    mau_pkg::OP_SUB:   res_reg <= sub_res;
                    mau_pkg::OP_NEG:   res_reg <= neg_res;
                    mau_pkg::OP_EQUAL: eq_reg  <= a_reg == b_reg;
                    mau_pkg::OP_DIV:
                    begin
                        ea_reg  <= b_reg;
                        eb_reg  <= modulus_reg;
                        u_reg   <= (W+3)'(1);
                        v_reg   <= '0;
                        cnt_reg <= '0;
                    end
                    mau_pkg::OP_POW:
                    begin
                        acc_reg  <= W'(1);
                        base_reg <= a_reg;
                    end
                    default:
                    begin
                        res_reg <= res_reg;
                    end
                endcase
            end
            mau_pkg::S_EUC:
            begin
                if (cnt_reg == '0)
                begin
                    if (eb_reg != '0)
                    begin
                        bs_reg  <= {eb_reg, {(W-1){1'b0}}};
                        tv_reg  <= '0;
                        cnt_reg <= mau_pkg::CNT_W'(W);
                    end
                end
                else
                begin
                    bs_reg  <= bs_reg >> 1;
                    tv_reg  <= div_tv;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_last)
                    begin
                        // End of one Euclid step: rotate remainders and coefficients.
                        ea_reg <= eb_reg;
                        eb_reg <= div_rem;
                        u_reg  <= v_reg;
                        v_reg  <= u_reg - div_tv;
                    end
                    else
                    begin
                        ea_reg <= div_rem;
                    end
                end
            end
            mau_pkg::S_MUL:
            begin
                if (mul_done)
                    res_reg <= mul_prod;
            end
            mau_pkg::S_POW:
            begin
                if (exp_reg == '0)
                    res_reg <= acc_reg;
            end
            mau_pkg::S_POW_ACC:
            begin
                if (mul_done)
                    acc_reg <= mul_prod;
            end
            mau_pkg::S_POW_SQ:
            begin
                if (mul_done)
                begin
                    base_reg <= mul_prod;
                    exp_reg  <= exp_reg >> 1;
                end
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.result   = out_res_reg;
    assign rsp.is_equal = out_eq_reg;

    // An accepted request always leaves the idle state.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != mau_pkg::S_IDLE)
        else $error("request accepted but controller stayed idle");

    // The multiplier only reports completion while the controller waits on it.
    a_mul_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == mau_pkg::S_MUL || state_reg == mau_pkg::S_POW_ACC
                      || state_reg == mau_pkg::S_POW_SQ))
        else $error("multiplier finished outside a multiply wait");

    // An equality hit never carries a nonzero residue.
    a_equal_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.is_equal |-> rsp.result == '0)
        else $error("equal response with nonzero result");

    // Delivered residues lie below the modulus when it is 2 or more.
    a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !m_small |-> rsp.result < modulus_reg)
        else $error("result not reduced below modulus");

endmodule

// File: bench/mau_chk.sv
// ----------------------------------------------------------------------------
// mau_chk
// Watches the request, response and modulus ports of the modular arithmetic
// unit, predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
module mau_chk
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [mau_pkg::RES_W-1:0] cfg_wr_data,
    mau_req_if                        req,
    mau_rsp_if                        rsp,
    output int                        err_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [mau_pkg::RES_W-1:0] result;
        logic                      is_equal;
    } residue_t;

    residue_t                  residue_q[$];
    logic [mau_pkg::RES_W-1:0] modulus;

    // Extended Euclid coefficient of b against m, signed like the hardware loop.
    function automatic logic [63:0] euclid_coeff(logic [63:0] bval, logic [63:0] m);
        longint x, y, u, v, t, tmp;
        x = bval;
        y = m;
        u = 1;
        v = 0;
        while (y != 0)
        begin
            t   = x / y;
            x   = x - t * y;
            tmp = x; x = y; y = tmp;
            u   = u - t * v;
            tmp = u; u = v; v = tmp;
        end
        u = u % longint'(m);
        if (u < 0)
            u = u + longint'(m);
        return u;
    endfunction

    function automatic logic [63:0] pow_mod(logic [63:0] base, logic [62:0] e,
                                            logic [63:0] m);
        logic [63:0] acc;
        acc = 1 % m;
        while (e != 0)
        begin
            if (e[0])
                acc = (acc * base) % m;
            base = (base * base) % m;
            e    = e >> 1;
        end
        return acc;
    endfunction

    function automatic residue_t predict_residue(mau_pkg::op_t op,
                                                 logic [mau_pkg::RES_W-1:0] ra,
                                                 logic [mau_pkg::RES_W-1:0] rb,
                                                 logic [mau_pkg::EXP_W-1:0] e,
                                                 logic [mau_pkg::RAW_W-1:0] raw,
                                                 logic [mau_pkg::RES_W-1:0] mod_val);
        logic [63:0] m, a, b, res, r;
        residue_t    out;
        m   = mod_val;
        res = 0;
        out = '0;
        if (m < 2)
        begin
            if (op == mau_pkg::OP_EQUAL)
                out.is_equal = (ra == rb);
        end
        else
        begin
            a = ra % m;
            b = rb % m;
            case (op)
                mau_pkg::OP_REDUCE:
                begin
                    if (raw[63])
                    begin
                        r   = (64'd0 - raw) % m;
                        res = (r != 0) ? m - r : 0;
                    end
                    else
                        res = raw % m;
                end
                mau_pkg::OP_ADD:
                begin
                    res = a + b;
                    if (res >= m)
                        res = res - m;
                end
                mau_pkg::OP_SUB:   res = (a >= b) ? a - b : a + m - b;
                mau_pkg::OP_MUL:   res = (a * b) % m;
                mau_pkg::OP_DIV:   res = (a * euclid_coeff(b, m)) % m;
                mau_pkg::OP_NEG:   res = (a != 0) ? m - a : 0;
                mau_pkg::OP_POW:   res = pow_mod(a, e, m);
                default:           out.is_equal = (a == b);
            endcase
        end
        out.result = res[mau_pkg::RES_W-1:0];
        return out;
    endfunction

    assign pending = residue_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        residue_t got, want;
        if (!rst_n)
        begin
            modulus   <= mau_pkg::MODULUS_RESET;
            err_count <= 0;
            residue_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
                modulus <= cfg_wr_data;
            if (req.valid && req.ready)
                residue_q.insert(residue_q.size(),
                                 predict_residue(mau_pkg::op_t'(req.op), req.operand_a,
                                                 req.operand_b, req.exponent,
                                                 req.raw_value, modulus));
            if (rsp.valid && rsp.ready)
            begin
                got.result   = rsp.result;
                got.is_equal = rsp.is_equal;
                if (residue_q.size() == 0)
                begin
                    $display("%t: unexpected beat result=%0d is_equal=%0b",
                             $realtime, got.result, got.is_equal);
                    err_count <= err_count + 1;
                end
                else
                begin
                    want = residue_q.pop_front();
                    if (got.result !== want.result || got.is_equal !== want.is_equal)
                    begin
                        $display("%t: mismatch expected result=%0d is_equal=%0b,",
                                 $realtime, want.result, want.is_equal,
                                 " actual result=%0d is_equal=%0b",
                                 got.result, got.is_equal);
                        err_count <= err_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the modular arithmetic unit: directed corner
// cases, then random operations over several moduli with random stalls on
// both channels, checked by mau_chk.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [mau_pkg::RES_W-1:0] res_t;
    typedef logic [mau_pkg::EXP_W-1:0] exp_t;
    typedef logic [mau_pkg::RAW_W-1:0] raw_t;

    localparam int WATCHDOG_LIMIT = 30000;
    localparam int LONG_HOLD      = 1500;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    res_t             cfg_wr_data;
    int               err_count;
    int               pending;

    // Idling on both channels is switched off for the last part of the run.
    bit               gaps_on;
    // Set by the sender to ask the response side for one long hold-off.
    bit               hold_request;
    bit               done;
    int               quiet_cycles;

    mau_req_if req ();
    mau_rsp_if rsp ();

    modular_arithmetic_unit_core u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req.sink),
        .rsp         (rsp.source)
    );

    mau_chk u_chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .rsp         (rsp),
        .err_count   (err_count),
        .pending     (pending)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Drive one request beat at the falling edge and hold it until the unit
    // takes it. Valid is left high so back-to-back beats need no dip.
    task automatic send_beat(mau_pkg::op_t op, res_t a, res_t b, exp_t e, raw_t raw);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            req.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req.valid     = 1'b1;
        req.op        = op;
        req.operand_a = a;
        req.operand_b = b;
        req.exponent  = e;
        req.raw_value = raw;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    // Wait until the unit has returned every predicted response.
    task automatic drain();
        @(negedge clk);
        req.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // The modulus is only rewritten while nothing is in flight.
    task automatic write_modulus(res_t value);
        drain();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    // Operand that mixes small values, values near the top of the field and
    // fully random ones, so every bit toggles and unreduced operands appear.
    function automatic res_t pick_operand(res_t m);
        case ($urandom_range(0, 5))
            0:       return res_t'($urandom_range(0, 3));
            1:       return (m > 1) ? res_t'(m - 1 - $urandom_range(0, 1)) : '0;
            2:       return res_t'($urandom);
            3:       return 31'h7FFFFFFF;
            default: return (m > 1) ? res_t'($urandom % m) : res_t'($urandom);
        endcase
    endfunction

    // Exponents stay short most of the time since long ones need one squaring
    // per bit and one more multiply per set bit.
    function automatic exp_t pick_exponent();
        case ($urandom_range(0, 9))
            0:       return exp_t'({$urandom, $urandom});
            1:       return '0;
            default: return exp_t'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic raw_t pick_raw();
        case ($urandom_range(0, 5))
            0:       return {1'b1, 63'd0};
            1:       return {1'b0, {63{1'b1}}};
            2:       return -raw_t'($urandom_range(0, 100));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_beats(int count, res_t m);
        mau_pkg::op_t op;
        for (int i = 0; i < count; i++)
        begin
            op = mau_pkg::op_t'($urandom_range(0, 7));
            send_beat(op, pick_operand(m), pick_operand(m), pick_exponent(),
                      pick_raw());
        end
    endtask

    // Response side: random stall bursts, plus one long hold-off when asked.
    always @(negedge clk)
    begin
        static int stall_left = 0;
        if (hold_request)
        begin
            stall_left   = LONG_HOLD;
            hold_request = 1'b0;
        end
        else if (stall_left == 0 && gaps_on && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 6);
        if (stall_left > 0)
        begin
            rsp.ready  = 1'b0;
            stall_left = stall_left - 1;
        end
        else
            rsp.ready = 1'b1;
    end

    // The watchdog ends the run when no beat moves on either channel for
    // too long; a worst-case power request stays well under the limit.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        res_t moduli[9];
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        req.valid     = 1'b0;
        req.op        = mau_pkg::OP_REDUCE;
        req.operand_a = '0;
        req.operand_b = '0;
        req.exponent  = '0;
        req.raw_value = '0;
        rsp.ready     = 1'b0;
        gaps_on       = 1'b1;
        hold_request  = 1'b0;
        done          = 1'b0;
        quiet_cycles  = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed corners under the reset modulus.
        send_beat(mau_pkg::OP_REDUCE, '0, '0, '0, {1'b1, 63'd0});
        send_beat(mau_pkg::OP_REDUCE, '0, '0, '0, {1'b0, {63{1'b1}}});
        send_beat(mau_pkg::OP_REDUCE, '0, '0, '0, '1);
        send_beat(mau_pkg::OP_REDUCE, '0, '0, '0, '0);
        send_beat(mau_pkg::OP_ADD, mau_pkg::MODULUS_RESET - 1'b1,
                  mau_pkg::MODULUS_RESET - 1'b1, '0, '0);
        send_beat(mau_pkg::OP_SUB, '0, mau_pkg::MODULUS_RESET - 1'b1, '0, '0);
        send_beat(mau_pkg::OP_MUL, mau_pkg::MODULUS_RESET - 1'b1,
                  mau_pkg::MODULUS_RESET - 1'b1, '0, '0);
        send_beat(mau_pkg::OP_DIV, res_t'(12345), '0, '0, '0);
        send_beat(mau_pkg::OP_DIV, res_t'(1), mau_pkg::MODULUS_RESET - 1'b1, '0, '0);
        send_beat(mau_pkg::OP_NEG, '0, '0, '0, '0);
        send_beat(mau_pkg::OP_NEG, res_t'(1), '0, '0, '0);
        send_beat(mau_pkg::OP_POW, res_t'(7), '0, '0, '0);
        send_beat(mau_pkg::OP_POW, res_t'(2), '0, '1, '0);
        send_beat(mau_pkg::OP_EQUAL, res_t'(5), res_t'(5), '0, '0);
        send_beat(mau_pkg::OP_EQUAL, res_t'(5), res_t'(6), '0, '0);
        send_beat(mau_pkg::OP_ADD, 31'h7FFFFFFF, 31'h7FFFFFFF, '0, '0);
        // A divisor sharing a factor with the modulus.
        write_modulus(res_t'(12));
        send_beat(mau_pkg::OP_DIV, res_t'(5), res_t'(8), '0, '0);
        send_beat(mau_pkg::OP_POW, res_t'(11), '0, '0, '0);
        // Degenerate moduli still report equality from the raw operands.
        write_modulus(res_t'(1));
        send_beat(mau_pkg::OP_EQUAL, res_t'(3), res_t'(3), '0, '0);
        send_beat(mau_pkg::OP_POW, res_t'(3), '0, '0, '0);
        write_modulus('0);
        send_beat(mau_pkg::OP_EQUAL, res_t'(3), res_t'(4), '0, '0);
        send_beat(mau_pkg::OP_MUL, res_t'(3), res_t'(4), '0, '0);
        write_modulus(31'h7FFFFFFF);
        send_beat(mau_pkg::OP_DIV, 31'h7FFFFFFE, 31'h7FFFFFFE, '0, '0);

        moduli = '{31'h7FFFFFFF, res_t'(2), res_t'(12), res_t'(65536),
                   mau_pkg::MODULUS_RESET, res_t'(7), res_t'(1),
                   res_t'($urandom | 32'h4000_0000), '0};
        for (int ph = 0; ph < 9; ph++)
        begin
            write_modulus(moduli[ph]);
            // The last phase runs with no idling on either side.
            gaps_on = (ph != 8);
            if (ph == 2)
            begin
                // Long response hold-off while requests keep coming, so the
                // output register fills and the input stalls.
                hold_request = 1'b1;
                random_beats(10, moduli[ph]);
            end
            random_beats(70, moduli[ph]);
            if (ph == 3)
                drain();
            random_beats(70, moduli[ph]);
        end

        drain();
        repeat (20) @(negedge clk);
        done = 1'b1;
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
